>>> rtl/ackfp_pkg.sv
// shared constants and types for the acknowledge frame parser
package ackfp_pkg;

	localparam logic [7:0] START_BYTE = 8'hB5;

	localparam int CountW = 9;

	// frame_kind codes
	localparam logic [1:0] KIND_BAD_SUM   = 2'd0;
	localparam logic [1:0] KIND_START_ACK = 2'd1;
	localparam logic [1:0] KIND_BLOCK_ACK = 2'd2;
	localparam logic [1:0] KIND_OTHER     = 2'd3;

	// checksum position at reset and for the two recognized lengths
	localparam logic [CountW-1:0] SPAN_RESET     = 9'd4;
	localparam logic [CountW-1:0] SPAN_START_ACK = 9'd5;
	localparam logic [CountW-1:0] SPAN_BLOCK_ACK = 9'd7;

	// byte positions after the start byte
	localparam logic [CountW-1:0] POS_LENGTH   = 9'd3;
	localparam logic [CountW-1:0] POS_BLOCK_HI = 9'd5;
	localparam logic [CountW-1:0] POS_BLOCK_LO = 9'd6;

	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [15:0] number;
	} result_t;

endpackage

>>> rtl/ackfp_parse_core.sv
// parser state and per-byte decode for the acknowledge frame parser
module ackfp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic                chunk_start,
	output ackfp_pkg::result_t  result
);
	import ackfp_pkg::*;

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_FRAME = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	logic [1:0]        phase_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] span_q;
	logic [7:0]        sum_q;
	logic [15:0]       block_q;

	logic [1:0]        cur_phase, nxt_phase;
	logic [CountW-1:0] cur_count, nxt_count;
	logic [CountW-1:0] cur_span, nxt_span;
	logic [7:0]        cur_sum, nxt_sum;
	logic [15:0]       cur_block, nxt_block;

	always_comb begin
		// chunk start clears the parser before the byte is seen
		if (chunk_start) begin
			cur_phase = PH_HUNT;
			cur_count = '0;
			cur_span  = SPAN_RESET;
			cur_sum   = '0;
			cur_block = '0;
		end else begin
			cur_phase = phase_q;
			cur_count = count_q;
			cur_span  = span_q;
			cur_sum   = sum_q;
			cur_block = block_q;
		end

		nxt_phase = cur_phase;
		nxt_count = cur_count;
		nxt_span  = cur_span;
		nxt_sum   = cur_sum;
		nxt_block = cur_block;
		result    = '0;

		unique case (cur_phase)
			PH_HUNT: begin
				if (rx_byte == START_BYTE) begin
					nxt_phase = PH_FRAME;
					nxt_count = 9'd1;
					nxt_span  = SPAN_RESET;
					nxt_sum   = '0;
					nxt_block = '0;
				end
			end
			PH_FRAME: begin
				if (cur_count < cur_span) begin
					nxt_sum = cur_sum + rx_byte;
					if (cur_count == POS_LENGTH)
						nxt_span = {1'b0, rx_byte} + SPAN_START_ACK;
					if (cur_count == POS_BLOCK_HI)
						nxt_block = {rx_byte, cur_block[7:0]};
					if (cur_count == POS_BLOCK_LO)
						nxt_block = {cur_block[15:8], rx_byte};
					nxt_count = cur_count + 9'd1;
				end else begin
					// checksum byte
					result.hit = 1'b1;
					priority if (rx_byte != cur_sum) begin
						result.kind = KIND_BAD_SUM;
					end else if (cur_span == SPAN_START_ACK) begin
						result.kind = KIND_START_ACK;
					end else if (cur_span == SPAN_BLOCK_ACK) begin
						result.kind   = KIND_BLOCK_ACK;
						result.number = cur_block;
					end else begin
						result.kind = KIND_OTHER;
					end
					nxt_phase = PH_DONE;
				end
			end
			default: begin
				// done, and the unused code, wait for a chunk start
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			span_q  <= SPAN_RESET;
			sum_q   <= '0;
			block_q <= '0;
		end else if (step) begin
			phase_q <= nxt_phase;
			count_q <= nxt_count;
			span_q  <= nxt_span;
			sum_q   <= nxt_sum;
			block_q <= nxt_block;
		end
	end

endmodule

>>> rtl/ack_frame_parser.sv
// acknowledge frame parser: byte input register, parser core, result register
// path: the core decodes the held byte; the result register drives result_valid
// throughput: one byte per cycle; only a stalled result register with a byte
//   waiting in the input register holds off the next byte
// reset: arst_n clears both valid flags and puts the parser into start-byte hunt
module ack_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic        chunk_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  frame_kind,
	output logic [15:0] ack_block
);
	import ackfp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// result register
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [15:0] number_q;

	logic    out_free;
	logic    advance;
	logic    load_s1;
	result_t res;

	// the result register can take a new result when empty or being drained
	assign out_free = !valid_q || !result_stall;
	// a byte in the input register is decoded and retired once there is room
	assign advance  = valid_s1 && out_free;
	assign load_s1  = !valid_s1 || advance;
	assign byte_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && byte_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= chunk_start;
		end
	end

	// parser state advances exactly once per retired beat
	ackfp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.chunk_start (start_s1),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= advance && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.hit) begin
			kind_q   <= res.kind;
			number_q <= res.number;
		end
	end

	assign result_valid = valid_q;
	assign frame_kind   = kind_q;
	assign ack_block    = number_q;

	// stall only comes from a held byte behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && valid_q && result_stall))
		else $error("input stalled without a blocked result");

	// only a block acknowledge carries a block number
	a_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_kind != KIND_BLOCK_ACK) |-> (ack_block == 16'd0))
		else $error("block number set on a non block ack result");

	// a held byte is never dropped while stalled
	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> (valid_s1 && $stable(byte_s1) && $stable(start_s1)))
		else $error("held input byte changed during stall");

endmodule
